[design/pmtu_pkg.sv]
// pmtu_pkg.sv: shared types, constants and register map of the multi-timer unit
`timescale 1ns / 1ps

package pmtu_pkg;

    // unit sizing
    localparam int NUM_TIMERS   = 7;
    localparam int TIMER_WIDTH  = 32;
    localparam int SCALER_WIDTH = 16;

    // fixed field widths of the item interface
    localparam int DATA_W = 32;
    localparam int ADDR_W = 6;
    localparam int IRQ_W  = 7;

    // command codes
    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_WRITE = 2'd2,
        CMD_NOP   = 2'd3
    } t_command;

    // unit-level register word indexes
    localparam logic [ADDR_W-1:0] ADDR_SCALER        = 6'd0;
    localparam logic [ADDR_W-1:0] ADDR_SCALER_RELOAD = 6'd1;
    localparam logic [ADDR_W-1:0] ADDR_UNIT_CFG      = 6'd2;

    // word within a timer's four-word slot
    localparam logic [1:0] WORD_VALUE  = 2'd0;
    localparam logic [1:0] WORD_RELOAD = 2'd1;
    localparam logic [1:0] WORD_CTRL   = 2'd2;

    // control register bit positions
    localparam int CTRL_W = 7;
    localparam int BIT_EN = 0;
    localparam int BIT_RS = 1;
    localparam int BIT_LD = 2;
    localparam int BIT_IE = 3;
    localparam int BIT_IP = 4;
    localparam int BIT_CH = 5;
    localparam int BIT_DH = 6;

    // bits copied straight from a control write (pending handled apart)
    localparam logic [CTRL_W-1:0] CTRL_DIRECT_MASK = 7'h6B;

    // unit config read value: timer count in the low three bits
    localparam logic [DATA_W-1:0] UNIT_CFG_VALUE = DATA_W'(NUM_TIMERS & 7);

    // input item
    typedef struct packed {
        logic [1:0]        command;
        logic [ADDR_W-1:0] reg_address;
        logic [DATA_W-1:0] write_data;
    } t_in_item;

    // result item
    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic [IRQ_W-1:0]  irq_lines;
        logic              irq_any;
    } t_out_item;

    // per-timer strobes from the unit decoder
    typedef struct packed {
        logic tick;
        logic wr_value;
        logic wr_reload;
        logic wr_ctrl;
        logic clear_by_one;
    } t_tmr_ctl;

endpackage

[design/pmtu_timer.sv]
// pmtu_timer.sv: one down-counting timer channel with reload and pending logic
`timescale 1ns / 1ps

module pmtu_timer
    import pmtu_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_tmr_ctl               i_ctl,
    input  logic [DATA_W-1:0]      i_wdata,
    output logic [TIMER_WIDTH-1:0] o_count,
    output logic [TIMER_WIDTH-1:0] o_reload,
    output logic [CTRL_W-1:0]      o_ctrl,
    output logic                   o_irq_next
);

    logic [TIMER_WIDTH-1:0] r_count, n_count;
    logic [TIMER_WIDTH-1:0] r_reload, n_reload;
    logic [CTRL_W-1:0]      r_ctrl, n_ctrl;
    logic                   w_keep_ip;

    // pending survives a control write unless the clearing level is written
    assign w_keep_ip = r_ctrl[BIT_IP] &&
                       (i_ctl.clear_by_one ? !i_wdata[BIT_IP] : i_wdata[BIT_IP]);

    // next state for a tick or a register write
    always_comb begin
        n_count  = r_count;
        n_reload = r_reload;
        n_ctrl   = r_ctrl;
        if (i_ctl.tick && r_ctrl[BIT_EN]) begin
            if (r_count == '0) begin
                if (r_ctrl[BIT_IE]) begin
                    n_ctrl[BIT_IP] = 1'b1;
                end
                if (r_ctrl[BIT_RS]) begin
                    n_count = r_reload;
                end else begin
                    n_count        = '1;
                    n_ctrl[BIT_EN] = 1'b0;
                end
            end else begin
                n_count = r_count - TIMER_WIDTH'(1);
            end
        end
        if (i_ctl.wr_value) begin
            n_count = i_wdata[TIMER_WIDTH-1:0];
        end
        if (i_ctl.wr_reload) begin
            n_reload = i_wdata[TIMER_WIDTH-1:0];
        end
        if (i_ctl.wr_ctrl) begin
            n_ctrl         = i_wdata[CTRL_W-1:0] & CTRL_DIRECT_MASK;
            n_ctrl[BIT_IP] = w_keep_ip;
            if (i_wdata[BIT_LD]) begin
                n_count = r_reload;
            end
        end
    end

    // channel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_reload <= '0;
            r_ctrl   <= '0;
        end else begin
            r_count  <= n_count;
            r_reload <= n_reload;
            r_ctrl   <= n_ctrl;
        end
    end

    assign o_count    = r_count;
    assign o_reload   = r_reload;
    assign o_ctrl     = r_ctrl;
    assign o_irq_next = n_ctrl[BIT_IP] && n_ctrl[BIT_IE];

endmodule

[design/prescaled_multi_timer_unit_core.sv]
// prescaled_multi_timer_unit_core.sv: top level of the prescaled multi-timer unit
`timescale 1ns / 1ps

// Timer unit with a shared prescaler and seven down-counting timers behind word
// registers. Each item is a tick, a register read, a register write or a
// no-op, and each gives exactly one result item carrying the read data (zero
// for ticks, writes and no-ops) and the interrupt lines as they stand after
// that item. An item sits in an input register, is decoded and applied to the
// timer state as its result is loaded into an output register, so the unit
// takes one item every clock cycle; a stall on the result side holds the
// output register and then the input register. The pending-clear polarity
// register is written through i_cfg_we/i_cfg_wdata.

module prescaled_multi_timer_unit_core
    import pmtu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    // item input
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    // result output
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item,
    // configuration
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata
);

    logic r_in_valid;
    t_in_item r_in;
    logic r_out_valid;
    t_out_item r_out, n_out;
    logic r_clear_by_one;

    logic [SCALER_WIDTH-1:0] r_scaler, n_scaler;
    logic [SCALER_WIDTH-1:0] r_scaler_reload, n_scaler_reload;

    logic w_advance;
    logic w_is_tick, w_is_read, w_is_write;
    logic w_timer_tick;
    logic [1:0] w_word;

    t_tmr_ctl               w_ctl   [NUM_TIMERS];
    logic [TIMER_WIDTH-1:0] w_count [NUM_TIMERS];
    logic [TIMER_WIDTH-1:0] w_reload[NUM_TIMERS];
    logic [CTRL_W-1:0]      w_ctrl  [NUM_TIMERS];
    logic [NUM_TIMERS-1:0]  w_irq;
    logic [NUM_TIMERS-1:0]  w_sel;

    // handshake: the held item moves on when the result register is free
    assign w_advance   = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !w_advance;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // item and result payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_item;
        end
        if (w_advance) begin
            r_out <= n_out;
        end
    end

    // pending-clear polarity
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clear_by_one <= 1'b1;
        end else if (i_cfg_we) begin
            r_clear_by_one <= i_cfg_wdata;
        end
    end

    // command decode
    assign w_is_tick  = w_advance && (r_in.command == CMD_TICK);
    assign w_is_read  = r_in.command == CMD_READ;
    assign w_is_write = w_advance && (r_in.command == CMD_WRITE);
    assign w_word     = r_in.reg_address[1:0];

    // prescaler: divides ticks by reload+1
    assign w_timer_tick = w_is_tick && (r_scaler == '0);

    always_comb begin
        n_scaler        = r_scaler;
        n_scaler_reload = r_scaler_reload;
        if (w_is_tick) begin
            n_scaler = (r_scaler == '0) ? r_scaler_reload : r_scaler - SCALER_WIDTH'(1);
        end
        if (w_is_write && r_in.reg_address == ADDR_SCALER) begin
            n_scaler = r_in.write_data[SCALER_WIDTH-1:0];
        end
        if (w_is_write && r_in.reg_address == ADDR_SCALER_RELOAD) begin
            n_scaler_reload = r_in.write_data[SCALER_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scaler        <= '1;
            r_scaler_reload <= '1;
        end else begin
            r_scaler        <= n_scaler;
            r_scaler_reload <= n_scaler_reload;
        end
    end

    // timer channels, timer n owns words 4n+4 to 4n+7
    for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_timer
        assign w_sel[g] = r_in.reg_address[ADDR_W-1:2] == (ADDR_W - 2)'(g + 1);

        assign w_ctl[g].tick         = w_timer_tick;
        assign w_ctl[g].wr_value     = w_is_write && w_sel[g] && (w_word == WORD_VALUE);
        assign w_ctl[g].wr_reload    = w_is_write && w_sel[g] && (w_word == WORD_RELOAD);
        assign w_ctl[g].wr_ctrl      = w_is_write && w_sel[g] && (w_word == WORD_CTRL);
        assign w_ctl[g].clear_by_one = r_clear_by_one;

        pmtu_timer u_timer (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl[g]),
            .i_wdata    (r_in.write_data),
            .o_count    (w_count[g]),
            .o_reload   (w_reload[g]),
            .o_ctrl     (w_ctrl[g]),
            .o_irq_next (w_irq[g])
        );
    end

    // result: read data mux and interrupt lines after this item
    always_comb begin
        n_out           = '0;
        n_out.irq_lines = IRQ_W'(w_irq);
        n_out.irq_any   = |w_irq;
        if (w_is_read) begin
            unique case (r_in.reg_address)
                ADDR_SCALER:        n_out.read_data = DATA_W'(r_scaler);
                ADDR_SCALER_RELOAD: n_out.read_data = DATA_W'(r_scaler_reload);
                ADDR_UNIT_CFG:      n_out.read_data = UNIT_CFG_VALUE;
                default: begin
                    for (int n = 0; n < NUM_TIMERS; n++) begin
                        if (w_sel[n]) begin
                            unique case (w_word)
                                WORD_VALUE:  n_out.read_data = DATA_W'(w_count[n]);
                                WORD_RELOAD: n_out.read_data = DATA_W'(w_reload[n]);
                                WORD_CTRL:   n_out.read_data = DATA_W'(w_ctrl[n]);
                                default:     n_out.read_data = '0;
                            endcase
                        end
                    end
                end
            endcase
        end
    end

endmodule

[dv/pmtu_result_checker.sv]
// pmtu_result_checker.sv: result predictor and checker for the multi-timer unit
`timescale 1ns / 1ps

module pmtu_result_checker
    import pmtu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_item  i_in_item,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_item i_out_item,
    input  logic      i_cfg_we,
    input  logic      i_cfg_wdata,
    output int        o_fail_count,
    output int        o_outstanding,
    output int        o_irq_results
);

    // shadow copy of the unit state
    logic [SCALER_WIDTH-1:0] scl_count;
    logic [SCALER_WIDTH-1:0] scl_reload;
    logic [TIMER_WIDTH-1:0]  tmr_count  [NUM_TIMERS];
    logic [TIMER_WIDTH-1:0]  tmr_reload [NUM_TIMERS];
    logic [CTRL_W-1:0]       tmr_ctrl   [NUM_TIMERS];
    logic                    clear_by_one;

    // results still owed by the unit, oldest first
    t_out_item due_results[$];
    t_out_item want;

    function automatic void reset_unit();
        scl_count    = '1;
        scl_reload   = '1;
        clear_by_one = 1'b1;
        for (int n = 0; n < NUM_TIMERS; n++) begin
            tmr_count[n]  = '0;
            tmr_reload[n] = '0;
            tmr_ctrl[n]   = '0;
        end
    endfunction

    // one prescaler underflow: every enabled timer counts down once
    function automatic void tick_timers();
        for (int n = 0; n < NUM_TIMERS; n++) begin
            if (tmr_ctrl[n][BIT_EN]) begin
                if (tmr_count[n] == '0) begin
                    if (tmr_ctrl[n][BIT_IE])
                        tmr_ctrl[n][BIT_IP] = 1'b1;
                    if (tmr_ctrl[n][BIT_RS]) begin
                        tmr_count[n] = tmr_reload[n];
                    end else begin
                        tmr_count[n]          = '1;
                        tmr_ctrl[n][BIT_EN] = 1'b0;
                    end
                end else begin
                    tmr_count[n] = tmr_count[n] - 1'b1;
                end
            end
        end
    endfunction

    function automatic logic [DATA_W-1:0] read_word(input logic [ADDR_W-1:0] a);
        int unsigned n;
        if (a == ADDR_SCALER)
            return DATA_W'(scl_count);
        if (a == ADDR_SCALER_RELOAD)
            return DATA_W'(scl_reload);
        if (a == ADDR_UNIT_CFG)
            return DATA_W'(NUM_TIMERS % 8);
        if (a < 4)
            return '0;
        n = (int'(a) - 4) / 4;
        if (n >= NUM_TIMERS)
            return '0;
        case (a[1:0])
            WORD_VALUE:  return DATA_W'(tmr_count[n]);
            WORD_RELOAD: return DATA_W'(tmr_reload[n]);
            WORD_CTRL:   return DATA_W'(tmr_ctrl[n]);
            default:     return '0;
        endcase
    endfunction

    function automatic void write_word(input logic [ADDR_W-1:0] a,
                                       input logic [DATA_W-1:0] d);
        int unsigned n;
        logic [CTRL_W-1:0] nc;
        logic keep_ip;
        if (a == ADDR_SCALER) begin
            scl_count = d[SCALER_WIDTH-1:0];
            return;
        end
        if (a == ADDR_SCALER_RELOAD) begin
            scl_reload = d[SCALER_WIDTH-1:0];
            return;
        end
        if (a < 4)
            return;
        n = (int'(a) - 4) / 4;
        if (n >= NUM_TIMERS)
            return;
        case (a[1:0])
            WORD_VALUE:  tmr_count[n]  = d[TIMER_WIDTH-1:0];
            WORD_RELOAD: tmr_reload[n] = d[TIMER_WIDTH-1:0];
            WORD_CTRL: begin
                // load is not stored, pending is only ever cleared by software
                nc = '0;
                nc[BIT_EN] = d[BIT_EN];
                nc[BIT_RS] = d[BIT_RS];
                nc[BIT_IE] = d[BIT_IE];
                nc[BIT_CH] = d[BIT_CH];
                nc[BIT_DH] = d[BIT_DH];
                keep_ip = tmr_ctrl[n][BIT_IP] && (clear_by_one ? !d[BIT_IP] : d[BIT_IP]);
                nc[BIT_IP] = keep_ip;
                tmr_ctrl[n] = nc;
                if (d[BIT_LD])
                    tmr_count[n] = tmr_reload[n];
            end
            default: ;
        endcase
    endfunction

    // apply one item to the shadow state and form its result
    function automatic t_out_item timer_unit_step(input t_in_item it);
        t_out_item r;
        r = '0;
        case (it.command)
            CMD_TICK: begin
                if (scl_count == '0) begin
                    scl_count = scl_reload;
                    tick_timers();
                end else begin
                    scl_count = scl_count - 1'b1;
                end
            end
            CMD_READ:  r.read_data = read_word(it.reg_address);
            CMD_WRITE: write_word(it.reg_address, it.write_data);
            default: ;
        endcase
        for (int n = 0; n < NUM_TIMERS; n++)
            r.irq_lines[n] = tmr_ctrl[n][BIT_IP] & tmr_ctrl[n][BIT_IE];
        r.irq_any = |r.irq_lines;
        return r;
    endfunction

    // watch both channels and the config port on every edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_unit();
            due_results.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (due_results.size() == 0) begin
                    $error("unexpected result item %h with nothing outstanding", i_out_item);
                    o_fail_count++;
                end else begin
                    want = due_results.pop_front();
                    if (i_out_item.irq_any === 1'b1)
                        o_irq_results++;
                    if (i_out_item.read_data !== want.read_data) begin
                        $error("read_data: expected %h, got %h",
                               want.read_data, i_out_item.read_data);
                        o_fail_count++;
                    end
                    if (i_out_item.irq_lines !== want.irq_lines) begin
                        $error("irq_lines: expected %b, got %b",
                               want.irq_lines, i_out_item.irq_lines);
                        o_fail_count++;
                    end
                    if (i_out_item.irq_any !== want.irq_any) begin
                        $error("irq_any: expected %b, got %b",
                               want.irq_any, i_out_item.irq_any);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg_we)
                clear_by_one = i_cfg_wdata;
            if (i_in_valid && !i_in_stall)
                due_results.push_back(timer_unit_step(i_in_item));
        end
        o_outstanding = due_results.size();
    end

endmodule

[dv/prescaled_multi_timer_unit_core_tb.sv]
// prescaled_multi_timer_unit_core_tb.sv: stimulus and verdict for the multi-timer unit
`timescale 1ns / 1ps

module prescaled_multi_timer_unit_core_tb;
    import pmtu_pkg::*;

    localparam int CYCLE_LIMIT    = 200_000;
    localparam int RANDOM_PHASES  = 5;
    localparam int PHASE_ITEMS    = 250;
    localparam logic [1:0] WORD_SPARE = 2'd3;

    // control word bits
    localparam logic [DATA_W-1:0] CT_EN = DATA_W'(1) << BIT_EN;
    localparam logic [DATA_W-1:0] CT_RS = DATA_W'(1) << BIT_RS;
    localparam logic [DATA_W-1:0] CT_LD = DATA_W'(1) << BIT_LD;
    localparam logic [DATA_W-1:0] CT_IE = DATA_W'(1) << BIT_IE;
    localparam logic [DATA_W-1:0] CT_IP = DATA_W'(1) << BIT_IP;
    localparam logic [DATA_W-1:0] CT_CH = DATA_W'(1) << BIT_CH;
    localparam logic [DATA_W-1:0] CT_DH = DATA_W'(1) << BIT_DH;

    logic      i_clk     = 1'b0;
    logic      i_rst_n   = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_item  in_item   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;
    logic      cfg_we    = 1'b0;
    logic      cfg_wdata = 1'b0;

    int fail_count;
    int o_fail_count_w;
    int outstanding;
    int irq_results;
    int cycle_count;
    int burst_left;
    int n_tick, n_read, n_write, n_nop;
    int unsigned stall_mode, stall_left;

    // clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    prescaled_multi_timer_unit_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    pmtu_result_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in_item     (in_item),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_item    (out_item),
        .i_cfg_we      (cfg_we),
        .i_cfg_wdata   (cfg_wdata),
        .o_fail_count  (o_fail_count_w),
        .o_outstanding (outstanding),
        .o_irq_results (irq_results)
    );

    assign fail_count = o_fail_count_w;

    // result-side stall: modes of random length, from none to heavy
    always @(posedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(50, 300);
        end else begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 9) < 6);
            default: out_stall <= stall_left[2];
        endcase
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("prescaled_multi_timer_unit_core_tb: errors");
            $finish;
        end
    end

    function automatic logic [ADDR_W-1:0] tmr_addr(input int unsigned n,
                                                   input logic [1:0] w);
        return ADDR_W'(4 + 4 * n + w);
    endfunction

    // present one item in bursts with random gaps, hold it until taken
    task automatic send_item(input t_in_item it);
        int unsigned gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_item  <= it;
        case (it.command)
            CMD_TICK:  n_tick++;
            CMD_READ:  n_read++;
            CMD_WRITE: n_write++;
            default:   n_nop++;
        endcase
        do @(posedge i_clk); while (in_stall);
    endtask

    task automatic send_cmd(input t_command cmd, input logic [ADDR_W-1:0] a,
                            input logic [DATA_W-1:0] d);
        t_in_item it;
        it.command     = cmd;
        it.reg_address = a;
        it.write_data  = d;
        send_item(it);
    endtask

    // hold the sender off until every result is back
    task automatic wait_idle();
        in_valid   <= 1'b0;
        burst_left = 0;
        @(negedge i_clk);
        while (outstanding != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic set_clear_polarity(input logic by_one);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= by_one;
        @(posedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    // random item, mostly well-aimed at live registers with small counts
    function automatic t_in_item random_item();
        t_in_item it;
        int unsigned pick;
        logic [DATA_W-1:0] r;
        it.write_data  = $urandom();
        it.reg_address = ADDR_W'($urandom_range(0, 63));
        pick = $urandom_range(0, 99);
        if (pick < 55)
            it.command = CMD_TICK;
        else if (pick < 70)
            it.command = CMD_READ;
        else if (pick < 95)
            it.command = CMD_WRITE;
        else
            it.command = CMD_NOP;
        if (it.command != CMD_TICK && $urandom_range(0, 9) != 0) begin
            if ($urandom_range(0, 4) == 0)
                it.reg_address = ADDR_W'($urandom_range(0, 3));
            else
                it.reg_address = tmr_addr($urandom_range(0, NUM_TIMERS - 1),
                                          2'($urandom_range(0, 3)));
        end
        if (it.command == CMD_WRITE) begin
            r = $urandom();
            if (it.reg_address == ADDR_SCALER || it.reg_address == ADDR_SCALER_RELOAD) begin
                // keep the prescaler fast, junk in the upper half
                if ($urandom_range(0, 19) != 0)
                    it.write_data = {r[31:16], 14'd0, r[1:0]};
            end else if (it.reg_address >= 4) begin
                case (it.reg_address[1:0])
                    WORD_VALUE, WORD_RELOAD: begin
                        pick = $urandom_range(0, 9);
                        if (pick < 8)
                            it.write_data = DATA_W'($urandom_range(0, 6));
                        else if (pick == 8)
                            it.write_data = '1;
                    end
                    WORD_CTRL: begin
                        it.write_data         = r;
                        it.write_data[BIT_EN] = ($urandom_range(0, 3) != 0);
                        it.write_data[BIT_LD] = ($urandom_range(0, 2) == 0);
                        it.write_data[BIT_IE] = ($urandom_range(0, 9) < 7);
                    end
                    default: ;
                endcase
            end
        end
        return it;
    endfunction

    initial begin
        // reset
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // unit registers, unmapped words, truncation
        send_cmd(CMD_READ,  ADDR_UNIT_CFG, '0);
        send_cmd(CMD_READ,  ADDR_SCALER, '1);
        send_cmd(CMD_READ,  ADDR_W'(3), '0);
        send_cmd(CMD_WRITE, ADDR_UNIT_CFG, '1);
        send_cmd(CMD_WRITE, ADDR_SCALER_RELOAD, 32'hFFFF_0000);
        send_cmd(CMD_WRITE, ADDR_SCALER, 32'hABCD_0000);
        send_cmd(CMD_READ,  ADDR_SCALER, '0);
        // timer 0 with restart: load, count to underflow, pending then clear
        send_cmd(CMD_WRITE, tmr_addr(0, WORD_RELOAD), 32'd1);
        send_cmd(CMD_WRITE, tmr_addr(0, WORD_CTRL), 32'hFFFF_FF80 | CT_EN | CT_RS | CT_LD | CT_IE);
        send_cmd(CMD_READ,  tmr_addr(0, WORD_VALUE), '0);
        repeat (3) send_cmd(CMD_TICK, '0, '0);
        send_cmd(CMD_READ,  tmr_addr(0, WORD_CTRL), '0);
        send_cmd(CMD_WRITE, tmr_addr(0, WORD_CTRL), CT_EN | CT_RS | CT_IE);
        send_cmd(CMD_WRITE, tmr_addr(0, WORD_CTRL), CT_EN | CT_RS | CT_IE | CT_IP | CT_CH | CT_DH);
        // last timer without restart: wraps to all ones and disables
        send_cmd(CMD_WRITE, tmr_addr(NUM_TIMERS - 1, WORD_CTRL), CT_EN | CT_IE);
        send_cmd(CMD_TICK,  '0, '1);
        send_cmd(CMD_READ,  tmr_addr(NUM_TIMERS - 1, WORD_VALUE), '0);
        send_cmd(CMD_NOP,   ADDR_W'(63), 32'h5A5A_A5A5);
        // words beyond the last timer and the spare word of the first slot
        send_cmd(CMD_WRITE, tmr_addr(NUM_TIMERS, WORD_VALUE), '1);
        send_cmd(CMD_READ,  tmr_addr(NUM_TIMERS, WORD_VALUE), '0);
        send_cmd(CMD_WRITE, tmr_addr(0, WORD_SPARE), '1);
        send_cmd(CMD_READ,  tmr_addr(0, WORD_SPARE), '0);
        send_cmd(CMD_WRITE, ADDR_W'(63), 32'h5555_5555);
        // clear by zero: a one keeps pending, a zero clears it
        set_clear_polarity(1'b0);
        send_cmd(CMD_WRITE, tmr_addr(NUM_TIMERS - 1, WORD_CTRL), CT_IE | CT_IP);
        send_cmd(CMD_WRITE, tmr_addr(NUM_TIMERS - 1, WORD_CTRL), CT_IE);

        // random phases, alternating the pending-clear polarity
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            set_clear_polarity(p % 2 == 0);
            for (int k = 0; k < PHASE_ITEMS; k++)
                send_item(random_item());
        end

        // drain and let the pipeline settle
        wait_idle();
        repeat (6) @(posedge i_clk);

        $display("run covered %0d ticks, %0d reads, %0d writes and %0d no-ops",
                 n_tick, n_read, n_write, n_nop);
        $display("under both pending-clear polarities; %0d results had an interrupt raised",
                 irq_results);
        if (fail_count == 0 && outstanding == 0)
            $display("prescaled_multi_timer_unit_core_tb: clean");
        else
            $display("prescaled_multi_timer_unit_core_tb: errors");
        $finish;
    end

endmodule
